>>> sv/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define S98P_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define S98P_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> sv/s98p_pkg.sv
// Types and constants for the sound-log command stream parser.
package s98p_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR,
      PH_DATA,
      PH_VARINT,
      PH_ENDED
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_WAIT,
      KIND_LOOP,
      KIND_END
   } kind_type;

   localparam logic [7:0] CMD_WRITE_LAST = 8'h7F;
   localparam logic [7:0] CMD_WAIT_ONE   = 8'hFF;
   localparam logic [7:0] CMD_WAIT_VAR   = 8'hFE;
   localparam logic [7:0] CMD_LOOP       = 8'hFD;

   localparam int          VARINT_BITS = 32;
   localparam logic [5:0]  VARINT_STEP = 6'd7;
   localparam logic [32:0] WAIT_BIAS   = 33'd2;
   localparam logic [32:0] WAIT_SINGLE = 33'd1;

   // Register index taken from the configuration address.
   localparam logic CSR_DEV_MASK = 1'b0;
   localparam logic CSR_LOOP     = 1'b1;

   typedef struct packed {
      phase_type    phase;
      logic [6:0]   command;
      logic [7:0]   address;
      logic [31:0]  value;
      logic [5:0]   shift;
   } parse_state_type;

   typedef struct packed {
      kind_type     kind;
      logic [5:0]   device_index;
      logic [8:0]   reg_address;
      logic [7:0]   reg_data;
      logic [32:0]  wait_syncs;
   } event_type;

endpackage

>>> sv/s98_command_stream_parser_top.sv
// Top level of the sound-log command stream parser with its register port.
// An event is registered and appears on rsp in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while req_tready is high; the parse state and output register update together.
// req_tready drops only while a finished event waits in the output register.
// Reset is synchronous: idle phase, output empty, mask = device 0 only, looping off.
module s98_command_stream_parser_top #(
   parameter int DEVICE_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] device_index, [14:6] reg_address, [22:15] reg_data, [55:23] wait_syncs
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import s98p_pkg::*;

   `include "assert_macros.svh"

   parse_state_type         state_ff, state_in;
   event_type               evt;
   logic                    evt_valid;
   logic [DEVICE_SLOTS-1:0] mask_ff;
   logic                    loop_ff;
   logic                    rsp_valid_ff;
   event_type               rsp_evt_ff;
   logic                    req_accept;
   logic                    csr_write;
   logic                    in_ended;
   logic                    end_taken;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      case (csr_paddr[3])
         CSR_DEV_MASK: csr_prdata = 64'(mask_ff);
         CSR_LOOP:     csr_prdata = 64'(loop_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= DEVICE_SLOTS'(1);
         loop_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[3] == CSR_DEV_MASK) begin
            mask_ff <= csr_pwdata[DEVICE_SLOTS-1:0];
         end else begin
            loop_ff <= csr_pwdata[0];
         end
      end
   end

   s98p_decode u_decode (
      .cur          (state_ff),
      .stream_byte  (req_tdata),
      .enable_mask  (64'(mask_ff)),
      .loop_enabled (loop_ff),
      .nxt          (state_in),
      .evt          (evt),
      .evt_valid    (evt_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         // The all-zero state is the idle phase with cleared holding fields.
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= evt_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && evt_valid) begin
         rsp_evt_ff <= evt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_evt_ff.kind;
   assign rsp_tdata  = {rsp_evt_ff.wait_syncs, rsp_evt_ff.reg_data,
                        rsp_evt_ff.reg_address, rsp_evt_ff.device_index};

   assign in_ended  = state_ff.phase == PH_ENDED;
   assign end_taken = req_accept && evt_valid && evt.kind == KIND_END;

   `S98P_ASSERT_NXT(a_ended_sticks, clock, reset, in_ended, in_ended)
   `S98P_ASSERT_NXT(a_end_enters_ended, clock, reset, end_taken, in_ended)
   `S98P_ASSERT_IMP(a_ended_silent, clock, reset, in_ended, !evt_valid)

endmodule

>>> sv/s98p_decode.sv
// Next-state and event decode for one stream byte.
module s98p_decode (
   input  s98p_pkg::parse_state_type cur,
   input  logic [7:0]                stream_byte,
   input  logic [63:0]               enable_mask,
   input  logic                      loop_enabled,
   output s98p_pkg::parse_state_type nxt,
   output s98p_pkg::event_type       evt,
   output logic                      evt_valid
);
   import s98p_pkg::*;

   logic [38:0] part;
   logic [5:0]  dev;

   assign dev = cur.command[6:1];

   always_comb begin
      nxt       = cur;
      evt       = '0;
      evt_valid = 1'b0;
      part      = 39'(stream_byte[6:0]) << cur.shift[4:0];
      case (cur.phase)
         PH_IDLE: begin
            if (stream_byte inside {[8'h00:CMD_WRITE_LAST]}) begin
               nxt.command = stream_byte[6:0];
               nxt.phase   = PH_ADDR;
            end else if (stream_byte == CMD_WAIT_ONE) begin
               evt.kind       = KIND_WAIT;
               evt.wait_syncs = WAIT_SINGLE;
               evt_valid      = 1'b1;
            end else if (stream_byte == CMD_WAIT_VAR) begin
               nxt.value = '0;
               nxt.shift = '0;
               nxt.phase = PH_VARINT;
            end else if (stream_byte == CMD_LOOP && loop_enabled) begin
               evt.kind  = KIND_LOOP;
               evt_valid = 1'b1;
            end else begin
               evt.kind  = KIND_END;
               evt_valid = 1'b1;
               nxt.phase = PH_ENDED;
            end
         end
         PH_ADDR: begin
            nxt.address = stream_byte;
            nxt.phase   = PH_DATA;
         end
         PH_DATA: begin
            nxt.phase = PH_IDLE;
            // Devices beyond the slot count read as zero bits of the mask.
            if (enable_mask[dev]) begin
               evt.kind         = KIND_WRITE;
               evt.device_index = dev;
               evt.reg_address  = {cur.command[0], cur.address};
               evt.reg_data     = stream_byte;
               evt_valid        = 1'b1;
            end
         end
         PH_VARINT: begin
            // Groups that start at bit 32 or above are dropped.
            if (cur.shift < 6'(VARINT_BITS)) begin
               nxt.value = cur.value | part[31:0];
               nxt.shift = cur.shift + VARINT_STEP;
            end
            if (!stream_byte[7]) begin
               nxt.phase      = PH_IDLE;
               evt.kind       = KIND_WAIT;
               evt.wait_syncs = 33'(nxt.value) + WAIT_BIAS;
               evt_valid      = 1'b1;
            end
         end
         PH_ENDED: begin
            nxt.phase = PH_ENDED;
         end
         default: begin
            nxt.phase = PH_ENDED;
         end
      endcase
   end

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the sound-log command stream parser top level.
`timescale 1ns / 100ps

module testbench;
   import s98p_pkg::*;

   localparam int DEVICE_SLOTS = 64;
   localparam int IDLE_LIMIT   = 3000;
   localparam int PHASE_BYTES  = 230;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata    = '0;
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel     = 1'b0;
   logic        csr_penable  = 1'b0;
   logic        csr_pwrite   = 1'b0;
   logic [3:0]  csr_paddr    = '0;
   logic [63:0] csr_pwdata   = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   // Parser state and register copies kept by the testbench.
   phase_type   parser_phase = PH_IDLE;
   logic [6:0]  held_cmd     = '0;
   logic [7:0]  held_addr    = '0;
   logic [31:0] varint_acc   = '0;
   logic [5:0]  varint_pos   = '0;
   logic [63:0] dev_mask     = 64'd1;
   logic        loop_on      = 1'b0;

   event_type   pending_events[$];
   int          error_count  = 0;
   int          idle_cycles  = 0;
   int          burst_left   = 0;
   int          gap_max      = 0;
   int          stall_level  = 0;
   int          bytes_sent   = 0;

   s98_command_stream_parser_top #(.DEVICE_SLOTS(DEVICE_SLOTS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Decode one accepted stream byte and queue the event it completes, if any.
   function automatic void decode_stream_byte(input logic [7:0] b);
      event_type   ev;
      logic [5:0]  dev;
      logic [63:0] part;
      ev = '0;
      case (parser_phase)
         PH_IDLE: begin
            if (b <= CMD_WRITE_LAST) begin
               held_cmd = b[6:0];
               parser_phase = PH_ADDR;
            end else if (b == CMD_WAIT_ONE) begin
               ev.kind = KIND_WAIT;
               ev.wait_syncs = WAIT_SINGLE;
               pending_events.push_back(ev);
            end else if (b == CMD_WAIT_VAR) begin
               varint_acc = '0;
               varint_pos = '0;
               parser_phase = PH_VARINT;
            end else if (b == CMD_LOOP && loop_on) begin
               ev.kind = KIND_LOOP;
               pending_events.push_back(ev);
            end else begin
               parser_phase = PH_ENDED;
               ev.kind = KIND_END;
               pending_events.push_back(ev);
            end
         end
         PH_ADDR: begin
            held_addr = b;
            parser_phase = PH_DATA;
         end
         PH_DATA: begin
            dev = held_cmd[6:1];
            parser_phase = PH_IDLE;
            if (int'(dev) < DEVICE_SLOTS && dev_mask[dev]) begin
               ev.kind = KIND_WRITE;
               ev.device_index = dev;
               ev.reg_address = {held_cmd[0], held_addr};
               ev.reg_data = b;
               pending_events.push_back(ev);
            end
         end
         PH_VARINT: begin
            // Groups past bit 31 are lost and the shift stops moving.
            if (int'(varint_pos) < VARINT_BITS) begin
               part = 64'(b[6:0]) << varint_pos;
               varint_acc = varint_acc | part[31:0];
               varint_pos = varint_pos + VARINT_STEP;
            end
            if (!b[7]) begin
               parser_phase = PH_IDLE;
               ev.kind = KIND_WAIT;
               ev.wait_syncs = {1'b0, varint_acc} + WAIT_BIAS;
               pending_events.push_back(ev);
            end
         end
         default: parser_phase = PH_ENDED;
      endcase
   endfunction

   // Send one item in bursts with random gaps between them.
   task automatic send_stream_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      decode_stream_byte(b);
   endtask

   task automatic csr_write(input logic idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_DEV_MASK) dev_mask = value;
      else loop_on = value[0];
   endtask

   // Stop sending, let every expected event arrive, then allow for the
   // registering of a last byte that produces no event.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [32:0] want,
                              input logic [32:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual kind %0d data 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", 33'(want.kind), 33'(rsp_tuser));
            check_field("device_index", 33'(want.device_index), 33'(rsp_tdata[5:0]));
            check_field("reg_address", 33'(want.reg_address), 33'(rsp_tdata[14:6]));
            check_field("reg_data", 33'(want.reg_data), 33'(rsp_tdata[22:15]));
            check_field("wait_syncs", want.wait_syncs, rsp_tdata[55:23]);
         end
      end
   end

   // Receiver back-pressure: random stalls whose density follows stall_level,
   // plus a recurring free-running window where it never stalls.
   always @(posedge clock) begin
      int cyc;
      cyc++;
      if (stall_level == 0 || cyc % 128 < 20) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 9) >= 2 * stall_level);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("s98_command_stream_parser_top verification failed");
         $finish;
      end
   end

   task automatic test_directed();
      logic [7:0] seq[$];
      stall_level = 1;
      gap_max = 2;
      // Writes to device 0 in both banks at the field extremes, then one to a
      // device that is disabled at reset.
      seq = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h02, 8'h5A, 8'hA5};
      // Single-sync wait, shortest variable wait, then a varint that runs past
      // bit 31 and gives the largest possible wait.
      seq = {seq, CMD_WAIT_ONE, CMD_WAIT_VAR, 8'h00};
      seq = {seq, CMD_WAIT_VAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
      foreach (seq[i]) send_stream_byte(seq[i]);
      wait_drained();
      csr_write(CSR_DEV_MASK, '1);
      csr_write(CSR_LOOP, 64'd1);
      // Highest device in the upper bank, then a loop request.
      seq = '{8'h7F, 8'hAB, 8'h55, CMD_LOOP};
      foreach (seq[i]) send_stream_byte(seq[i]);
      wait_drained();
   endtask

   task automatic send_random_command();
      int         pick;
      int         len;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         send_stream_byte(8'($urandom_range(0, 127)));
         send_stream_byte(8'($urandom_range(0, 255)));
         send_stream_byte(8'($urandom_range(0, 255)));
      end else if (pick < 62) begin
         send_stream_byte(CMD_WAIT_ONE);
      end else if (pick < 82) begin
         len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 7);
         send_stream_byte(CMD_WAIT_VAR);
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            b[7] = (i < len - 1);
            send_stream_byte(b);
         end
      end else if (pick < 90) begin
         send_stream_byte(loop_on ? CMD_LOOP : CMD_WAIT_ONE);
      end else begin
         // Noise: a byte from 0x00 to 0x7F mid-command, any byte that keeps the stream alive
         // at a command boundary.
         if (parser_phase != PH_IDLE) begin
            send_stream_byte(8'($urandom_range(0, 127)));
         end else begin
            case ($urandom_range(0, 3))
               0: send_stream_byte(8'($urandom_range(0, 127)));
               1: send_stream_byte(CMD_WAIT_VAR);
               2: send_stream_byte(CMD_WAIT_ONE);
               default: send_stream_byte(loop_on ? CMD_LOOP : CMD_WAIT_ONE);
            endcase
         end
         // Finish whatever the noise opened so the next command starts at a
         // boundary and the stream never reaches its end by accident.
         while (parser_phase != PH_IDLE) send_stream_byte(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic test_random_streams();
      int          first_byte;
      logic [63:0] mask;
      for (int ph = 0; ph < 6; ph++) begin
         mask = {$urandom(), $urandom()};
         case (ph)
            0: begin
               csr_write(CSR_DEV_MASK, '1);
               csr_write(CSR_LOOP, 64'd1);
               stall_level = 0;
               gap_max = 0;
            end
            1: begin
               csr_write(CSR_DEV_MASK, '0);
               csr_write(CSR_LOOP, 64'd0);
               stall_level = 2;
               gap_max = 5;
            end
            2: begin
               csr_write(CSR_DEV_MASK, mask);
               csr_write(CSR_LOOP, 64'd1);
               stall_level = 4;
               gap_max = 3;
            end
            3: begin
               csr_write(CSR_DEV_MASK, 64'd1);
               csr_write(CSR_LOOP, 64'd0);
               stall_level = 1;
               gap_max = 12;
            end
            4: begin
               csr_write(CSR_DEV_MASK, mask & {$urandom(), $urandom()});
               csr_write(CSR_LOOP, 64'($urandom_range(0, 1)));
               stall_level = $urandom_range(0, 4);
               gap_max = $urandom_range(0, 8);
            end
            default: begin
               csr_write(CSR_DEV_MASK, 64'h8000_0000_0000_0001);
               csr_write(CSR_LOOP, 64'd1);
               stall_level = 3;
               gap_max = 2;
            end
         endcase
         first_byte = bytes_sent;
         while (bytes_sent - first_byte < PHASE_BYTES) begin
            send_random_command();
         end
         // Close any command left open by noise so the phase ends at a boundary.
         while (parser_phase != PH_IDLE) send_stream_byte(8'($urandom_range(0, 127)));
         wait_drained();
      end
   endtask

   task automatic test_stream_end();
      csr_write(CSR_LOOP, 64'd0);
      stall_level = 2;
      gap_max = 3;
      // With looping off the loop byte ends the stream; everything after it,
      // commands included, must be swallowed without an event.
      send_stream_byte(CMD_LOOP);
      repeat (12) send_stream_byte(8'($urandom_range(0, 255)));
      send_stream_byte(CMD_WAIT_ONE);
      send_stream_byte(8'h00);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_streams();
      test_stream_end();
      if (error_count == 0 && pending_events.size() == 0)
         $display("s98_command_stream_parser_top verification clean");
      else
         $display("s98_command_stream_parser_top verification failed");
      $finish;
   end

endmodule
